[rtl/core/lif_pkg.sv]
// ----------------------------------------------------------------------------
// lif_pkg: shared types and constants of the spiking network step core
// Table layouts, opcode and register codes, controller states.
// ----------------------------------------------------------------------------
package lif_pkg;

    localparam int MAX_NEURONS  = 1024;
    localparam int NIDX_W       = 10;
    localparam int NCNT_W       = 11;
    localparam int SIDX_W       = 13;
    localparam int SCNT_W       = 14;
    localparam int SLOT_W       = 4;
    localparam int RING_AW      = SLOT_W + NIDX_W;
    localparam int Q_W          = 24;
    localparam int OUT_CH       = 16;
    localparam int IN_CH        = 64;

    typedef enum logic [2:0] {
        OP_LOAD_NEURON  = 3'd0,
        OP_LOAD_SYNAPSE = 3'd1,
        OP_INJECT       = 3'd2,
        OP_TICK         = 3'd3,
        OP_READ         = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        CFG_DECAY      = 3'd0,
        CFG_THRESHOLD  = 3'd1,
        CFG_RESET_POT  = 3'd2,
        CFG_REFRACTORY = 3'd3,
        CFG_NEURONS    = 3'd4,
        CFG_IN_CH      = 3'd5,
        CFG_OUT_CH     = 3'd6
    } cfg_idx_t;

    typedef enum logic [0:0] {
        KIND_SUMMARY = 1'b0,
        KIND_COUNT   = 1'b1
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INJ_RD,
        ST_INJ_WB,
        ST_TK_RD,
        ST_TK_MUL,
        ST_TK_WB,
        ST_TK_TOT,
        ST_SC_FL,
        ST_SC_NI,
        ST_SC_CNT,
        ST_SC_E,
        ST_SC_SR,
        ST_SC_SW,
        ST_TK_EMIT,
        ST_RD_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]        role;
        logic signed [6:0] chan;
        logic [1:0]        sgn;
        logic [13:0]       edge_first;
        logic [13:0]       edge_end;
    } neuron_info_t;

    typedef struct packed {
        logic [9:0]         target;
        logic signed [15:0] wt;
        logic [3:0]         dly;
    } synapse_info_t;

    typedef struct packed {
        logic signed [23:0] membrane;
        logic [7:0]         refr;
        logic signed [23:0] drive;
    } nstate_t;

endpackage

[rtl/core/lif_spiking_network_step_core.sv]
// ----------------------------------------------------------------------------
// lif_spiking_network_step_core: leaky integrate-and-fire network engine
// Neuron and synapse tables, delay ring and per-neuron state in block RAM.
// ----------------------------------------------------------------------------
// Usage
// s_ channel: one command per transfer, opcode in s_tuser (load neuron,
//   load synapse, inject, tick, read and clear), operands in s_tdata.
// m_ channel: results; s_tuser-like kind in m_tuser (0 summary, 1 count),
//   m_tlast on the final result of a command.
// cfg channel: register writes, index and data, always ready.
// Sequencing
//   loads: taken in the idle state. inject: a read, then a write-back, per neuron in use.
//   tick: read, multiply and write-back per neuron in use, then per fired neuron
//   a fetch and count step plus a ring read and write per outgoing synapse, all
//   paced by the single port of the state and ring memories; one summary result follows.
//   read: one result per output channel (one summary if there are none), then a
//   clearing pass over the 16384-entry delay ring and the neuron state.
// Reset runs the same clearing pass; s_tready stays low during it.
// One result register decouples the sides: a stalled receiver holds the core
// only when a further result has to be written.
// ----------------------------------------------------------------------------
module lif_spiking_network_step_core
    import lif_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // input commands
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index, role, channel, sign, edge_first, edge_end, target_neuron,
    // weight, delay, amplitude, zero pad
    input  logic [103:0] s_tdata,
    // op
    input  logic [2:0]   s_tuser,
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_channel, spike_count, total_spikes, event_total, zero pad
    output logic [95:0]  m_tdata,
    // result_kind
    output logic         m_tuser,
    output logic         m_tlast,
    // configuration
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
        if (v > 27'sd8388607)       return 24'sh7FFFFF;
        else if (v < -27'sd8388608) return 24'sh800000;
        else                        return v[23:0];
    endfunction

    // input field unpack
    logic [12:0]        in_index;
    logic [1:0]         in_role;
    logic signed [6:0]  in_chan;
    logic [1:0]         in_sign;
    logic [13:0]        in_first;
    logic [13:0]        in_end;
    logic [9:0]         in_target;
    logic signed [15:0] in_weight;
    logic [3:0]         in_delay;
    logic signed [15:0] in_amp;
    op_t                in_op;

    assign in_index  = s_tdata[12:0];
    assign in_role   = s_tdata[14:13];
    assign in_chan   = s_tdata[21:15];
    assign in_sign   = s_tdata[23:22];
    assign in_first  = s_tdata[37:24];
    assign in_end    = s_tdata[51:38];
    assign in_target = s_tdata[61:52];
    assign in_weight = s_tdata[77:62];
    assign in_delay  = s_tdata[81:78];
    assign in_amp    = s_tdata[97:82];
    assign in_op     = op_t'(s_tuser);

    // registers
    state_t state_reg, state_next;
    logic [15:0]        decay_reg;
    logic signed [23:0] thr_reg;
    logic signed [23:0] rpot_reg;
    logic [7:0]         refr_steps_reg;
    logic [10:0]        ncount_reg;
    logic [6:0]         icount_reg;
    logic [4:0]         ocount_reg;

    logic [SLOT_W-1:0]  pos_reg;
    logic [31:0]        spike_total_reg;
    logic [39:0]        event_total_reg;
    logic [15:0]        cnt_reg [OUT_CH];
    logic [RING_AW-1:0] clr_cnt_reg;

    logic [NCNT_W-1:0]  idx_reg;
    logic [NCNT_W-1:0]  nf_reg;
    logic [NCNT_W-1:0]  k_reg;
    logic [4:0]         rk_reg;
    logic signed [6:0]  inj_ch_reg;
    logic signed [15:0] amp_reg;
    logic signed [40:0] prod_reg;
    logic [SCNT_W-1:0]  e_reg;
    logic [SCNT_W-1:0]  end_reg;
    logic [1:0]         sgn_reg;
    logic               dlv_reg;
    logic signed [16:0] w_reg;
    logic [RING_AW-1:0] ring_addr_reg;

    logic               m_valid_reg;
    logic               out_kind_reg;
    logic [3:0]         out_ch_reg;
    logic [15:0]        out_cnt_reg;
    logic [31:0]        out_tot_reg;
    logic [39:0]        out_ev_reg;
    logic               out_last_reg;

    // effective counts
    logic [10:0] n_eff;
    logic [6:0]  ic_eff;
    logic [4:0]  oc_eff;
    assign n_eff  = (ncount_reg > 11'd1024) ? 11'd1024 : ncount_reg;
    assign ic_eff = (icount_reg > 7'd64) ? 7'd64 : icount_reg;
    assign oc_eff = (ocount_reg > 5'd16) ? 5'd16 : ocount_reg;

    logic s_acc, out_free, inj_ok;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign inj_ok    = !in_chan[6] && ({1'b0, in_chan[5:0]} < ic_eff);

    // memories
    nstate_t       nst_mem [MAX_NEURONS];
    nstate_t       nst_rd_reg, nst_wdata;
    logic          nst_we, nst_re;
    logic [NIDX_W-1:0] nst_addr;

    logic signed [23:0] ring_mem [1 << RING_AW];
    logic signed [23:0] ring_rd_reg, ring_wdata;
    logic               ring_we, ring_re;
    logic [RING_AW-1:0] ring_addr;

    neuron_info_t  ni_mem [MAX_NEURONS];
    neuron_info_t  ni_rd_reg, ni_wdata;
    logic          ni_we, ni_re;
    logic [NIDX_W-1:0] ni_addr;

    synapse_info_t syn_mem [1 << SIDX_W];
    synapse_info_t syn_rd_reg, syn_wdata;
    logic          syn_we, syn_re;
    logic [SIDX_W-1:0] syn_addr;

    logic [NIDX_W-1:0] fl_mem [MAX_NEURONS];
    logic [NIDX_W-1:0] fl_rd_reg;
    logic              fl_we, fl_re;

    always_ff @(posedge aclk) begin
        if (nst_we) nst_mem[nst_addr] <= nst_wdata;
        if (nst_re) nst_rd_reg <= nst_mem[nst_addr];
    end

    always_ff @(posedge aclk) begin
        if (ring_we) ring_mem[ring_addr] <= ring_wdata;
        if (ring_re) ring_rd_reg <= ring_mem[ring_addr];
    end

    always_ff @(posedge aclk) begin
        if (ni_we) ni_mem[ni_addr] <= ni_wdata;
        if (ni_re) ni_rd_reg <= ni_mem[ni_addr];
    end

    always_ff @(posedge aclk) begin
        if (syn_we) syn_mem[syn_addr] <= syn_wdata;
        if (syn_re) syn_rd_reg <= syn_mem[syn_addr];
    end

    always_ff @(posedge aclk) begin
        if (fl_we) fl_mem[nf_reg[NIDX_W-1:0]] <= idx_reg[NIDX_W-1:0];
        if (fl_re) fl_rd_reg <= fl_mem[k_reg[NIDX_W-1:0]];
    end

    // neuron update arithmetic
    logic signed [40:0] dec_sum;
    logic signed [24:0] dec;
    logic signed [23:0] v_new;
    logic               fire;
    assign dec_sum = prod_reg + 41'sd32768;
    assign dec     = dec_sum[40:16];
    assign v_new   = sat24(27'(dec) + 27'(nst_rd_reg.drive) + 27'(ring_rd_reg));
    assign fire    = (nst_rd_reg.refr == 8'd0) && (v_new >= thr_reg);

    // inject arithmetic
    logic inj_hit;
    assign inj_hit = (ni_rd_reg.role == 2'd1) && (ni_rd_reg.chan == inj_ch_reg);

    // scatter
    logic [SLOT_W-1:0] dslot;
    assign dslot = pos_reg + syn_rd_reg.dly;

    // memory port control
    always_comb begin
        nst_we = 1'b0; nst_re = 1'b0; nst_addr = idx_reg[NIDX_W-1:0];
        nst_wdata = nst_rd_reg;
        ring_we = 1'b0; ring_re = 1'b0; ring_addr = {pos_reg, idx_reg[NIDX_W-1:0]};
        ring_wdata = '0;
        ni_we = 1'b0; ni_re = 1'b0; ni_addr = idx_reg[NIDX_W-1:0];
        ni_wdata = '{role: in_role, chan: in_chan,
                     sgn: in_sign[1] ? 2'b11 : in_sign,
                     edge_first: in_first, edge_end: in_end};
        syn_we = 1'b0; syn_re = 1'b0; syn_addr = e_reg[SIDX_W-1:0];
        syn_wdata = '{target: in_target, wt: in_weight,
                      dly: (in_delay == 4'd0) ? 4'd1 : in_delay};
        fl_we = 1'b0; fl_re = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                nst_we = 1'b1; nst_addr = clr_cnt_reg[NIDX_W-1:0]; nst_wdata = '0;
                ring_we = 1'b1; ring_addr = clr_cnt_reg;
            end
            ST_IDLE: begin
                ni_addr  = in_index[NIDX_W-1:0];
                syn_addr = in_index;
                if (s_acc && in_op == OP_LOAD_NEURON)
                    ni_we = (in_index[12:NIDX_W] == '0);
                if (s_acc && in_op == OP_LOAD_SYNAPSE)
                    syn_we = 1'b1;
            end
            ST_INJ_RD: begin
                nst_re = 1'b1; ni_re = 1'b1;
            end
            ST_INJ_WB: begin
                nst_we = inj_hit;
                nst_wdata.drive = sat24(27'(nst_rd_reg.drive) + 27'(amp_reg));
            end
            ST_TK_RD: begin
                nst_re = 1'b1; ring_re = 1'b1;
            end
            ST_TK_WB: begin
                nst_we = 1'b1; ring_we = 1'b1; fl_we = fire;
                nst_wdata.drive = '0;
                if (nst_rd_reg.refr != 8'd0) begin
                    nst_wdata.refr     = nst_rd_reg.refr - 8'd1;
                    nst_wdata.membrane = rpot_reg;
                end else if (fire) begin
                    nst_wdata.refr     = refr_steps_reg;
                    nst_wdata.membrane = rpot_reg;
                end else begin
                    nst_wdata.membrane = v_new;
                end
            end
            ST_SC_FL: fl_re = (k_reg != nf_reg);
            ST_SC_NI: begin
                ni_re = 1'b1; ni_addr = fl_rd_reg;
            end
            ST_SC_E:  syn_re = (e_reg < end_reg);
            ST_SC_SR: begin
                ring_re = 1'b1; ring_addr = {dslot, syn_rd_reg.target};
            end
            ST_SC_SW: begin
                ring_we = dlv_reg; ring_addr = ring_addr_reg;
                ring_wdata = sat24(27'(ring_rd_reg) + 27'(w_reg));
            end
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_CLEAR;
        else          state_reg <= state_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == '1) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_acc) begin
                    case (in_op)
                        OP_INJECT: if (inj_ok && n_eff != '0) state_next = ST_INJ_RD;
                        OP_TICK:   state_next = (n_eff == '0) ? ST_TK_EMIT : ST_TK_RD;
                        OP_READ:   state_next = ST_RD_EMIT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INJ_RD: state_next = ST_INJ_WB;
            ST_INJ_WB: state_next = (idx_reg + 11'd1 == n_eff) ? ST_IDLE : ST_INJ_RD;
            ST_TK_RD:  state_next = ST_TK_MUL;
            ST_TK_MUL: state_next = ST_TK_WB;
            ST_TK_WB:  state_next = (idx_reg + 11'd1 == n_eff) ? ST_TK_TOT : ST_TK_RD;
            ST_TK_TOT: state_next = ST_SC_FL;
            ST_SC_FL:  state_next = (k_reg == nf_reg) ? ST_TK_EMIT : ST_SC_NI;
            ST_SC_NI:  state_next = ST_SC_CNT;
            ST_SC_CNT: state_next = ST_SC_E;
            ST_SC_E:   state_next = (e_reg < end_reg) ? ST_SC_SR : ST_SC_FL;
            ST_SC_SR:  state_next = ST_SC_SW;
            ST_SC_SW:  state_next = ST_SC_E;
            ST_TK_EMIT: if (out_free) state_next = ST_IDLE;
            ST_RD_EMIT: begin
                if (out_free && (oc_eff == '0 || rk_reg + 5'd1 == oc_eff))
                    state_next = ST_CLEAR;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sample counters, configuration, result register
    logic        rd_last;
    logic        out_load;
    logic [32:0] tot_sum;
    assign rd_last  = (oc_eff == '0) || (rk_reg + 5'd1 == oc_eff);
    assign out_load = out_free && (state_reg == ST_TK_EMIT || state_reg == ST_RD_EMIT);
    assign tot_sum  = {1'b0, spike_total_reg} + 33'(nf_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg       <= 16'd62259;
            thr_reg         <= 24'sd4096;
            rpot_reg        <= '0;
            refr_steps_reg  <= 8'd2;
            ncount_reg      <= 11'd1024;
            icount_reg      <= 7'd64;
            ocount_reg      <= 5'd16;
            pos_reg         <= '0;
            spike_total_reg <= '0;
            event_total_reg <= '0;
            for (int i = 0; i < OUT_CH; i++) cnt_reg[i] <= '0;
            clr_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_valid) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_DECAY:      decay_reg      <= cfg_data[15:0];
                    CFG_THRESHOLD:  thr_reg        <= cfg_data;
                    CFG_RESET_POT:  rpot_reg       <= cfg_data;
                    CFG_REFRACTORY: refr_steps_reg <= cfg_data[7:0];
                    CFG_NEURONS:    ncount_reg     <= cfg_data[10:0];
                    CFG_IN_CH:      icount_reg     <= cfg_data[6:0];
                    CFG_OUT_CH:     ocount_reg     <= cfg_data[4:0];
                    default: ;
                endcase
            end

            // result register loads on emit, drains on transfer
            if (out_load)                    m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;

            clr_cnt_reg <= (state_reg == ST_CLEAR) ? clr_cnt_reg + 1'b1 : '0;

            case (state_reg)
                ST_TK_TOT: spike_total_reg <= tot_sum[32] ? '1 : tot_sum[31:0];
                ST_SC_FL:  if (k_reg == nf_reg) pos_reg <= pos_reg + 1'b1;
                ST_SC_CNT: begin
                    if (ni_rd_reg.role == 2'd2 && !ni_rd_reg.chan[6] &&
                        {1'b0, ni_rd_reg.chan[5:0]} < 7'(oc_eff) &&
                        cnt_reg[ni_rd_reg.chan[3:0]] != 16'hFFFF)
                        cnt_reg[ni_rd_reg.chan[3:0]] <= cnt_reg[ni_rd_reg.chan[3:0]] + 1'b1;
                end
                ST_SC_SW:  if (event_total_reg != '1) event_total_reg <= event_total_reg + 1'b1;
                ST_RD_EMIT: begin
                    if (out_free && rd_last) begin
                        // clear the sample once the last result is loaded
                        pos_reg         <= '0;
                        spike_total_reg <= '0;
                        event_total_reg <= '0;
                        for (int i = 0; i < OUT_CH; i++) cnt_reg[i] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                idx_reg    <= '0;
                nf_reg     <= '0;
                rk_reg     <= '0;
                inj_ch_reg <= in_chan;
                amp_reg    <= in_amp;
            end
            ST_INJ_WB: idx_reg <= idx_reg + 1'b1;
            ST_TK_MUL: prod_reg <= nst_rd_reg.membrane * $signed({1'b0, decay_reg});
            ST_TK_WB: begin
                idx_reg <= idx_reg + 1'b1;
                if (fire) nf_reg <= nf_reg + 1'b1;
            end
            ST_TK_TOT: k_reg <= '0;
            ST_SC_CNT: begin
                e_reg   <= ni_rd_reg.edge_first;
                end_reg <= (ni_rd_reg.edge_end > 14'd8192) ? 14'd8192 : ni_rd_reg.edge_end;
                sgn_reg <= ni_rd_reg.sgn;
                k_reg   <= k_reg + 1'b1;
            end
            ST_SC_SR: begin
                dlv_reg       <= (11'(syn_rd_reg.target) < n_eff) && (sgn_reg != 2'b00);
                w_reg         <= sgn_reg[1] ? -17'(syn_rd_reg.wt) : 17'(syn_rd_reg.wt);
                ring_addr_reg <= {dslot, syn_rd_reg.target};
            end
            ST_SC_SW: e_reg <= e_reg + 1'b1;
            ST_TK_EMIT: begin
                if (out_free) begin
                    out_kind_reg <= KIND_SUMMARY;
                    out_ch_reg   <= '0;
                    out_cnt_reg  <= 16'(nf_reg);
                    out_tot_reg  <= spike_total_reg;
                    out_ev_reg   <= event_total_reg;
                    out_last_reg <= 1'b1;
                end
            end
            ST_RD_EMIT: begin
                if (out_free) begin
                    rk_reg       <= rk_reg + 1'b1;
                    out_kind_reg <= (oc_eff == '0) ? KIND_SUMMARY : KIND_COUNT;
                    out_ch_reg   <= rk_reg[3:0];
                    out_cnt_reg  <= (oc_eff == '0) ? 16'd0 : cnt_reg[rk_reg[3:0]];
                    out_tot_reg  <= spike_total_reg;
                    out_ev_reg   <= event_total_reg;
                    out_last_reg <= rd_last;
                end
            end
            default: ;
        endcase
    end

    // result port
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_ev_reg, out_tot_reg, out_cnt_reg, out_ch_reg};

endmodule

[rtl/core/lif_checker.sv]
// ----------------------------------------------------------------------------
// lif_checker: port-level checks of the spiking network step core
// Watches the result and command channels over time.
// ----------------------------------------------------------------------------
module lif_checker
    import lif_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [2:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [95:0]  m_tdata,
    input logic         m_tuser,
    input logic         m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a tick leaves the core busy in the cycle after it is taken
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_TICK |=> !s_tready)
        else $error("command taken during tick");

    // a summary is always the final result of its command
    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_SUMMARY |-> m_tlast)
        else $error("summary without last");

endmodule

bind lif_spiking_network_step_core lif_checker u_lif_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
